@@ hdl/rmt_pkg.sv @@
// ---------------------------------------------------------------------------
// rmt_pkg
// Shared widths, register indexes and types of the red marker tracker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmt_pkg;

  localparam int COLOR_WIDTH = 10;
  localparam int COORD_WIDTH = 10;

  // Stream payload sizes, padded to whole bytes.
  localparam int IN_BITS    = 2 * COORD_WIDTH + 3 * COLOR_WIDTH;
  localparam int OUT_BITS   = 3 * COLOR_WIDTH + 3 * COORD_WIDTH;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_DATA_W  = (COLOR_WIDTH > COORD_WIDTH) ? COLOR_WIDTH : COORD_WIDTH;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_BOUNDARY  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_BOUNDARY = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_MIN        = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OTHER_MAX      = 2'd3;

  localparam logic [COORD_WIDTH-1:0] LEFT_BOUNDARY_RST  = COORD_WIDTH'(300);
  localparam logic [COORD_WIDTH-1:0] RIGHT_BOUNDARY_RST = COORD_WIDTH'(600);
  localparam logic [COLOR_WIDTH-1:0] RED_MIN_RST        = COLOR_WIDTH'(600);
  localparam logic [COLOR_WIDTH-1:0] OTHER_MAX_RST      = COLOR_WIDTH'(350);

  localparam logic [COLOR_WIDTH-1:0] COLOR_FULL = '1;
  localparam logic [COLOR_WIDTH-1:0] COLOR_NONE = '0;

  typedef logic [COLOR_WIDTH-1:0] color_t;
  typedef logic [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t left_boundary;
    coord_t right_boundary;
    color_t red_min;
    color_t other_max;
  } cfg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t r;
    color_t g;
    color_t b;
  } pixel_t;

  // Latched marker positions as they stand after the current pixel.
  typedef struct packed {
    coord_t left_pos;
    coord_t right_pos;
    coord_t row_pos;
  } marker_t;

  // True when two coordinates differ by at most one.
  function automatic logic near_one(input coord_t a, input coord_t b);
    logic [COORD_WIDTH:0] wa;
    logic [COORD_WIDTH:0] wb;
    wa = {1'b0, a};
    wb = {1'b0, b};
    return (wa == wb) || (wa == wb + 1'b1) || (wb == wa + 1'b1);
  endfunction

endpackage

`default_nettype wire

@@ hdl/rmt_track.sv @@
// ---------------------------------------------------------------------------
// rmt_track
// Marker detection and the latched left, right and row positions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmt_track
  import rmt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    advance,
  input  wire pixel_t  pixel,
  input  wire cfg_t    cfg,
  output marker_t      marker
);

  coord_t left_pos;
  coord_t right_pos;
  coord_t row_pos;
  logic   left_found;
  logic   right_found;

  coord_t left_pos_next;
  coord_t right_pos_next;
  coord_t row_pos_next;
  logic   left_found_next;
  logic   right_found_next;
  logic   marker_pixel;

  assign marker_pixel = (pixel.r > cfg.red_min) && (pixel.g < cfg.other_max) &&
                        (pixel.b < cfg.other_max);

  // The left window wins when both windows would claim the pixel.
  always_comb begin
    left_pos_next    = left_pos;
    right_pos_next   = right_pos;
    row_pos_next     = row_pos;
    left_found_next  = left_found;
    right_found_next = right_found;
    priority if (pixel.x < cfg.left_boundary && !left_found) begin
      if (marker_pixel) begin
        left_pos_next   = pixel.x;
        row_pos_next    = pixel.y;
        left_found_next = 1'b1;
      end
    end else if (pixel.x > cfg.right_boundary && !right_found) begin
      if (marker_pixel) begin
        right_pos_next   = pixel.x;
        right_found_next = 1'b1;
      end
    end else begin
      // Neither search applies to this pixel; the markers hold.
      left_found_next = left_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pos    <= '0;
      right_pos   <= '0;
      row_pos     <= '0;
      left_found  <= 1'b0;
      right_found <= 1'b0;
    end else if (advance) begin
      left_pos    <= left_pos_next;
      right_pos   <= right_pos_next;
      row_pos     <= row_pos_next;
      left_found  <= left_found_next;
      right_found <= right_found_next;
    end
  end

  assign marker.left_pos  = left_pos_next;
  assign marker.right_pos = right_pos_next;
  assign marker.row_pos   = row_pos_next;

endmodule

`default_nettype wire

@@ hdl/rmt_overlay.sv @@
// ---------------------------------------------------------------------------
// rmt_overlay
// Recolors one pixel: magenta near a marker, cyan where red dominates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmt_overlay
  import rmt_pkg::*;
(
  input  wire pixel_t  pixel,
  input  wire marker_t marker,
  output color_t       out_red,
  output color_t       out_green,
  output color_t       out_blue
);

  logic                   near_marker;
  logic                   red_dominant;
  logic [COLOR_WIDTH+1:0] r_wide;
  logic [COLOR_WIDTH+1:0] g_triple;
  logic [COLOR_WIDTH+1:0] b_triple;

  assign near_marker = (near_one(pixel.x, marker.left_pos) ||
                        near_one(pixel.x, marker.right_pos)) &&
                       near_one(pixel.y, marker.row_pos);

  // Three times a component, as a shift plus add with two spare bits.
  assign r_wide   = {2'b00, pixel.r};
  assign g_triple = {1'b0, pixel.g, 1'b0} + {2'b00, pixel.g};
  assign b_triple = {1'b0, pixel.b, 1'b0} + {2'b00, pixel.b};
  assign red_dominant = (r_wide > b_triple) && (r_wide > g_triple);

  always_comb begin
    priority if (near_marker) begin
      out_red   = COLOR_FULL;
      out_green = COLOR_NONE;
      out_blue  = COLOR_FULL;
    end else if (red_dominant) begin
      out_red   = COLOR_NONE;
      out_green = COLOR_FULL;
      out_blue  = COLOR_FULL;
    end else begin
      out_red   = pixel.r;
      out_green = pixel.g;
      out_blue  = pixel.b;
    end
  end

endmodule

`default_nettype wire

@@ hdl/red_marker_track_and_overlay_unit.sv @@
// ---------------------------------------------------------------------------
// red_marker_track_and_overlay_unit
// Tracks a left and a right red marker in a pixel stream and overlays them.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake               Contents
// s_*       in         s_tvalid / s_tready     one pixel: x, y, red, green, blue
// m_*       out        m_tvalid / m_tready     recolored pixel and marker positions
// cfg_*     in         cfg_we (no wait)        boundaries and color thresholds
//
// Each pixel passes through the input register and then the result register,
// with short combinational logic between them; its result is loaded when the
// result register is empty or its contents are being taken. One pixel can be
// transferred in every cycle while results are taken. Reset (rst, synchronous)
// clears both valid flags, the marker flags and positions, and loads the
// register defaults. When the result is not taken, the input register holds
// one more pixel and then s_tready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module red_marker_track_and_overlay_unit
  import rmt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,

  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // From bit 0: pixel_x, pixel_y, in_red, in_green, in_blue, zero padding.
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,

  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // From bit 0: out_red, out_green, out_blue, left_x, right_x, marker_y,
  // zero padding.
  output logic [OUT_TDATA_W-1:0]      m_tdata,

  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  pixel_t  in_pixel;
  logic    in_valid;
  logic    out_valid;
  logic    advance;
  marker_t marker;
  color_t  ovl_red;
  color_t  ovl_green;
  color_t  ovl_blue;

  // Configuration registers; user writes only while the block is idle (unchecked).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_boundary  <= LEFT_BOUNDARY_RST;
      cfg.right_boundary <= RIGHT_BOUNDARY_RST;
      cfg.red_min        <= RED_MIN_RST;
      cfg.other_max      <= OTHER_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_BOUNDARY:  cfg.left_boundary  <= cfg_data[COORD_WIDTH-1:0];
        REG_RIGHT_BOUNDARY: cfg.right_boundary <= cfg_data[COORD_WIDTH-1:0];
        REG_RED_MIN:        cfg.red_min        <= cfg_data[COLOR_WIDTH-1:0];
        REG_OTHER_MAX:      cfg.other_max      <= cfg_data[COLOR_WIDTH-1:0];
        default:            ;
      endcase
    end
  end

  // The pixel in the input register moves on whenever the result register is
  // empty or its contents are being taken in this cycle. The marker state is
  // updated in the same cycle, so pixels are processed strictly in order.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pixel.x <= s_tdata[COORD_WIDTH-1:0];
      in_pixel.y <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      in_pixel.r <= s_tdata[2*COORD_WIDTH+COLOR_WIDTH-1:2*COORD_WIDTH];
      in_pixel.g <= s_tdata[2*COORD_WIDTH+2*COLOR_WIDTH-1:2*COORD_WIDTH+COLOR_WIDTH];
      in_pixel.b <= s_tdata[2*COORD_WIDTH+3*COLOR_WIDTH-1:2*COORD_WIDTH+2*COLOR_WIDTH];
    end
  end

  rmt_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .pixel   (in_pixel),
    .cfg     (cfg),
    .marker  (marker)
  );

  // The overlay sees the positions as updated by this very pixel.
  rmt_overlay u_overlay (
    .pixel     (in_pixel),
    .marker    (marker),
    .out_red   (ovl_red),
    .out_green (ovl_green),
    .out_blue  (ovl_blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= OUT_TDATA_W'({marker.row_pos, marker.right_pos, marker.left_pos,
                               ovl_blue, ovl_green, ovl_red});
    end
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

@@ hdl/rmt_checker.sv @@
// ---------------------------------------------------------------------------
// rmt_checker
// Port-level checks of the red marker tracker, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmt_checker
  import rmt_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  // A result that is not taken stays offered with the same contents.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // The input side only stalls when a result is waiting and not taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  // A result appearing on an empty output comes from a pixel that was taken in
  // and moved from the input register to the result register without waiting.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result offered without a matching input transfer");

endmodule

bind red_marker_track_and_overlay_unit rmt_checker u_rmt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
